/* rtl/core/nbnd_pkg.sv */
// ----------------------------------------------------------------------------
// NetBIOS name decoder package
// Shared types, character constants and the pair decode function.
// ----------------------------------------------------------------------------
package nbnd_pkg;

	localparam int NBND_NAME_BYTES = 16;
	localparam int NBND_IDX_W      = $clog2(NBND_NAME_BYTES);

	typedef logic [7:0]            nbnd_byte_t;
	typedef logic [8:0]            nbnd_len_t;
	typedef logic [NBND_IDX_W-1:0] nbnd_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BLANK   = 2'd2,
		ST_TRUNC   = 2'd3
	} nbnd_status_t;

	typedef struct packed {
		logic      blank;
		nbnd_idx_t top;
	} nbnd_trim_t;

	localparam nbnd_byte_t NBND_FIRST_LEN  = 8'd32;
	localparam nbnd_byte_t NBND_CHAR_A     = 8'h41;
	localparam nbnd_byte_t NBND_CHAR_SPACE = 8'h20;
	localparam nbnd_byte_t NBND_CHAR_DOT   = 8'h2E;
	localparam nbnd_byte_t NBND_NIBBLE_MSK = 8'd15;
	localparam nbnd_len_t  NBND_MAX_LEN_RST = 9'd256;

	function automatic nbnd_byte_t nbnd_decode_pair(input nbnd_byte_t hi, input nbnd_byte_t lo);
		nbnd_byte_t hi_d;
		nbnd_byte_t lo_d;
		hi_d = hi - NBND_CHAR_A;
		lo_d = lo - NBND_CHAR_A;
		return {hi_d[3:0], 4'b0000} | lo_d;
	endfunction

endpackage

/* rtl/core/nbnd_trim.sv */
// ----------------------------------------------------------------------------
// NetBIOS name trim search
// Finds the last name byte that is neither a space nor zero.
// ----------------------------------------------------------------------------
module nbnd_trim (
	input  nbnd_pkg::nbnd_byte_t bytes [nbnd_pkg::NBND_NAME_BYTES],
	output nbnd_pkg::nbnd_trim_t trim
);
	import nbnd_pkg::*;

	always_comb begin
		trim.blank = 1'b1;
		trim.top   = '0;
		for (int i = 0; i < NBND_NAME_BYTES; i++) begin
			if (bytes[i] != NBND_CHAR_SPACE && bytes[i] != 8'd0) begin
				trim.blank = 1'b0;
				trim.top   = NBND_IDX_W'(i);
			end
		end
	end

endmodule

/* rtl/core/netbios_name_decoder.sv */
// ----------------------------------------------------------------------------
// NetBIOS name decoder
// Decodes an encoded NetBIOS name field into the printable dotted name.
// ----------------------------------------------------------------------------
// The encoded field enters on the s_ stream one byte per request, with
// s_tuser set on the length byte that opens a new name. Decoded bytes leave
// on the m_ stream: tdata carries the byte and the running length, tuser the
// status and tlast marks the final result of a name. The cfg channel writes
// the maximum name length and is always ready.
// A request is held in an input register and decoded into the output
// register once that register is free. One request is taken every cycle
// while the receiver is ready, except after the last character of the
// first-level name: the trimmed name of up to 16 bytes is then sent one
// byte per cycle from internal storage while the receiver is ready, and
// new requests wait in the input register until it has been sent.
// When the receiver stalls, the output register holds its result, one more
// request is taken into the input register and then s_tready falls.
// Reset empties both registers, returns to idle and sets the maximum length
// to 256.
// ----------------------------------------------------------------------------
module netbios_name_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  nbnd_pkg::nbnd_len_t  cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] in_byte
	input  logic                 s_tuser,   // [0] start_req
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [7:0] out_byte, [16:8] name_length, rest zero
	output logic                 m_tlast,   // last
	output logic [1:0]           m_tuser    // [1:0] status
);
	import nbnd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_LEN,
		PH_DATA,
		PH_BURST
	} phase_t;

	phase_t       phase_q, phase_nxt;
	nbnd_byte_t   held_q, held_nxt;
	logic [4:0]   pair_q, pair_nxt;
	nbnd_byte_t   label_q, label_nxt;
	nbnd_len_t    emitted_q, emitted_nxt;
	logic         cut_q, cut_nxt;
	nbnd_idx_t    bidx_q, bidx_nxt;
	nbnd_idx_t    btop_q, btop_nxt;
	nbnd_len_t    max_len_q;
	nbnd_byte_t   name_q [NBND_NAME_BYTES];
	nbnd_byte_t   trim_bytes [NBND_NAME_BYTES];
	nbnd_trim_t   trim;

	logic         s1_valid;
	nbnd_byte_t   s1_byte;
	logic         s1_start;

	logic         out_free, proc_go, burst_go, out_load, name_we;
	nbnd_byte_t   decoded, o_byte;
	logic         o_last;
	nbnd_status_t o_status;
	nbnd_len_t    o_len, burst_len;
	logic [9:0]   label_sum;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;
	assign proc_go   = s1_valid && out_free && phase_q != PH_BURST;
	assign burst_go  = phase_q == PH_BURST && out_free;
	assign s_tready  = !s1_valid || proc_go;
	assign decoded   = nbnd_decode_pair(held_q, s1_byte);
	assign burst_len = nbnd_len_t'(bidx_q) + 9'd1;
	assign label_sum = {1'b0, emitted_q} + 10'd1 + {2'b00, s1_byte};

	always_comb begin
		for (int i = 0; i < NBND_NAME_BYTES; i++) begin
			trim_bytes[i] = (i == NBND_NAME_BYTES - 1) ? decoded : name_q[i];
		end
	end

	nbnd_trim u_trim (
		.bytes (trim_bytes),
		.trim  (trim)
	);

	always_comb begin
		phase_nxt   = phase_q;
		held_nxt    = held_q;
		pair_nxt    = pair_q;
		label_nxt   = label_q;
		emitted_nxt = emitted_q;
		cut_nxt     = cut_q;
		bidx_nxt    = bidx_q;
		btop_nxt    = btop_q;
		name_we     = 1'b0;
		out_load    = 1'b0;
		o_byte      = '0;
		o_last      = 1'b0;
		o_status    = ST_OK;
		o_len       = '0;
		if (burst_go) begin
			out_load = 1'b1;
			o_byte   = name_q[bidx_q];
			o_len    = burst_len;
			if (bidx_q == btop_q) begin
				phase_nxt   = PH_LEN;
				emitted_nxt = burst_len;
			end else begin
				bidx_nxt = bidx_q + 1'b1;
			end
		end else if (proc_go) begin
			if (s1_start) begin
				cut_nxt     = 1'b0;
				emitted_nxt = '0;
				label_nxt   = '0;
				pair_nxt    = '0;
				held_nxt    = '0;
				if (s1_byte != NBND_FIRST_LEN) begin
					out_load  = 1'b1;
					o_last    = 1'b1;
					o_status  = ST_BAD_LEN;
					phase_nxt = PH_IDLE;
				end else begin
					phase_nxt = PH_HIGH;
				end
			end else begin
				case (phase_q)
					PH_HIGH: begin
						held_nxt  = s1_byte;
						phase_nxt = PH_LOW;
					end
					PH_LOW: begin
						name_we  = 1'b1;
						pair_nxt = pair_q + 5'd1;
						if (!pair_nxt[4]) begin
							phase_nxt = PH_HIGH;
						end else if (trim.blank) begin
							out_load  = 1'b1;
							o_last    = 1'b1;
							o_status  = ST_BLANK;
							phase_nxt = PH_IDLE;
						end else begin
							bidx_nxt  = '0;
							btop_nxt  = trim.top;
							phase_nxt = PH_BURST;
						end
					end
					PH_LEN: begin
						if (s1_byte == 8'd0) begin
							out_load  = 1'b1;
							o_last    = 1'b1;
							o_status  = cut_q ? ST_TRUNC : ST_OK;
							o_len     = emitted_q;
							phase_nxt = PH_IDLE;
						end else begin
							label_nxt = s1_byte;
							phase_nxt = PH_DATA;
							if (!cut_q) begin
								if (label_sum > {1'b0, max_len_q}) begin
									cut_nxt = 1'b1;
								end else begin
									emitted_nxt = emitted_q + 9'd1;
									out_load    = 1'b1;
									o_byte      = NBND_CHAR_DOT;
									o_len       = emitted_nxt;
								end
							end
						end
					end
					PH_DATA: begin
						if (!cut_q) begin
							emitted_nxt = emitted_q + 9'd1;
							out_load    = 1'b1;
							o_byte      = s1_byte;
							o_len       = emitted_nxt;
						end
						label_nxt = label_q - 8'd1;
						if (label_q == 8'd1) begin
							phase_nxt = PH_LEN;
						end
					end
					default: begin
						phase_nxt = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			held_q    <= '0;
			pair_q    <= '0;
			label_q   <= '0;
			emitted_q <= '0;
			cut_q     <= 1'b0;
			bidx_q    <= '0;
			btop_q    <= '0;
			max_len_q <= NBND_MAX_LEN_RST;
			s1_valid  <= 1'b0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tlast   <= 1'b0;
			m_tuser   <= '0;
		end else begin
			phase_q   <= phase_nxt;
			held_q    <= held_nxt;
			pair_q    <= pair_nxt;
			label_q   <= label_nxt;
			emitted_q <= emitted_nxt;
			cut_q     <= cut_nxt;
			bidx_q    <= bidx_nxt;
			btop_q    <= btop_nxt;
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				s1_valid <= 1'b1;
			end else if (proc_go) begin
				s1_valid <= 1'b0;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {7'd0, o_len, o_byte};
				m_tlast  <= o_last;
				m_tuser  <= o_status;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_byte  <= s_tdata;
			s1_start <= s_tuser;
		end
		if (name_we) begin
			name_q[pair_q[NBND_IDX_W-1:0]] <= decoded;
		end
	end

endmodule
